[design/rfr_pkg.sv]
// Package for the radio fragment reassembler: field widths, reset values
// and the result record type. No dependencies.
`timescale 1ns / 1ps

package rfr_pkg;

  // Data bytes that follow the sequence byte in one radio payload.
  localparam int unsigned FRAG_DATA_BYTES_DEF = 31;

  // Width and reset value of the packet length limit register.
  localparam int unsigned MAX_LEN_W     = 13;
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 13'd1500;

  // Header bytes held back until the total length is known.
  localparam int unsigned HDR_BYTES = 4;

  // One result transaction.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_end;
    logic       packet_abort;
  } rfr_result_t;

endpackage

[design/rfr_stream_if.sv]
// Valid/ready stream interfaces for the reassembler's input bytes and
// result bytes. Depends on rfr_pkg.
`timescale 1ns / 1ps

interface rfr_in_if
  import rfr_pkg::*;
  ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frag_start;

  modport source (output valid, output rx_byte, output frag_start, input ready);
  modport sink   (input valid, input rx_byte, input frag_start, output ready);
endinterface

interface rfr_out_if
  import rfr_pkg::*;
  ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       packet_end;
  logic       packet_abort;

  modport source (output valid, output data_byte, output packet_end,
                  output packet_abort, input ready);
  modport sink   (input valid, input data_byte, input packet_end,
                  input packet_abort, output ready);
endinterface

[design/radio_fragment_reassembler_unit.sv]
// Top level of the radio fragment reassembler: byte parser, sequence check
// and five-entry result queue. Depends on rfr_pkg and rfr_stream_if.
`timescale 1ns / 1ps

// Rebuilds IPv4 packets from radio payloads (a sequence byte flagged by
// frag_start, then FRAG_DATA_BYTES data bytes). One input byte is taken per
// cycle while in_ch.ready is high; its results are written straight into a
// five-entry result queue that drains one transaction per cycle while
// out_ch.ready is high. Most bytes give zero or one result, so with a ready
// output the block sustains one byte per cycle. The fourth data byte of a
// first payload releases up to four header bytes at once; the queue absorbs
// them and in_ch.ready stays low while more than one result would remain
// queued, so after a header the input waits while the queue drains. Packets
// with a length of zero or above max_len_r are dropped without any output;
// a sequence mismatch mid-packet gives one result with packet_abort set.
// cfg_wr_data should be written only while the block is idle.
module radio_fragment_reassembler_unit
  import rfr_pkg::*;
#(
  parameter int unsigned FRAG_DATA_BYTES = FRAG_DATA_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  rfr_in_if.sink               in_ch,
  rfr_out_if.source            out_ch,
  input  logic                 cfg_wr_en,
  input  logic [MAX_LEN_W-1:0] cfg_wr_data
);

  localparam int unsigned POS_W = $clog2(FRAG_DATA_BYTES + 1);
  localparam int unsigned QD    = HDR_BYTES + 1;
  localparam int unsigned CNT_W = $clog2(QD + 1);
  localparam int unsigned NR_W  = $clog2(HDR_BYTES + 1);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_BODY   = 2'd2;

  // Parser state.
  logic [1:0]           phase_r, phase_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [7:0]           exp_seq_r, exp_seq_nxt;
  logic [7:0]           len_hi_r, len_hi_nxt;
  logic [MAX_LEN_W-1:0] pkt_len_r, pkt_len_nxt;
  logic [MAX_LEN_W-1:0] bytes_out_r, bytes_out_nxt;
  logic [15:0]          held_r, held_nxt;
  logic [MAX_LEN_W-1:0] max_len_r;

  // Result queue.
  rfr_result_t          queue_r [QD];
  rfr_result_t          queue_nxt [QD];
  logic [CNT_W-1:0]     cnt_r, cnt_nxt, base;

  rfr_result_t          res [HDR_BYTES];
  logic [NR_W-1:0]      n_res;
  logic                 acc, drain;
  logic [15:0]          len16;
  logic [MAX_LEN_W-1:0] bytes_inc;

  // Handshakes: room for a full header burst once this cycle's drain is done.
  assign drain       = (cnt_r != '0) && out_ch.ready;
  assign in_ch.ready = (cnt_r <= CNT_W'(1)) || ((cnt_r == CNT_W'(2)) && out_ch.ready);
  assign acc         = in_ch.valid && in_ch.ready;

  assign out_ch.valid        = (cnt_r != '0);
  assign out_ch.data_byte    = queue_r[0].data_byte;
  assign out_ch.packet_end   = queue_r[0].packet_end;
  assign out_ch.packet_abort = queue_r[0].packet_abort;

  assign len16     = {len_hi_r, in_ch.rx_byte};
  assign bytes_inc = bytes_out_r + MAX_LEN_W'(1);

  // Byte parser: next state and the results of the accepted transaction.
  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    exp_seq_nxt   = exp_seq_r;
    len_hi_nxt    = len_hi_r;
    pkt_len_nxt   = pkt_len_r;
    bytes_out_nxt = bytes_out_r;
    held_nxt      = held_r;
    n_res         = '0;
    for (int k = 0; k < HDR_BYTES; k++) begin
      res[k] = '0;
    end

    if (acc) begin
      if (in_ch.frag_start) begin
        pos_nxt = '0;
        if (phase_r == PH_BODY) begin
          if (in_ch.rx_byte == exp_seq_r) begin
            exp_seq_nxt = exp_seq_r + 8'd1;
          end else begin
            res[0].packet_abort = 1'b1;
            n_res               = NR_W'(1);
            phase_nxt           = PH_IDLE;
          end
        end else if (in_ch.rx_byte == 8'd0) begin
          phase_nxt     = PH_HEADER;
          held_nxt      = '0;
          len_hi_nxt    = '0;
          pkt_len_nxt   = '0;
          bytes_out_nxt = '0;
          exp_seq_nxt   = 8'd1;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end else if ((phase_r != PH_IDLE) && (pos_r < POS_W'(FRAG_DATA_BYTES))) begin
        pos_nxt = pos_r + POS_W'(1);
        if (phase_r == PH_HEADER) begin
          case (pos_r)
            POS_W'(0): held_nxt[15:8] = in_ch.rx_byte;
            POS_W'(1): held_nxt[7:0]  = in_ch.rx_byte;
            POS_W'(2): len_hi_nxt     = in_ch.rx_byte;
            default: begin
              // Length complete: drop it or release the held header bytes.
              pkt_len_nxt = len16[MAX_LEN_W-1:0];
              if ((len16 == 16'd0) || (len16 > {3'b000, max_len_r})) begin
                phase_nxt = PH_IDLE;
              end else begin
                res[0].data_byte  = held_r[15:8];
                res[0].packet_end = (len16 == 16'd1);
                res[1].data_byte  = held_r[7:0];
                res[1].packet_end = (len16 == 16'd2);
                res[2].data_byte  = len_hi_r;
                res[2].packet_end = (len16 == 16'd3);
                res[3].data_byte  = in_ch.rx_byte;
                res[3].packet_end = (len16 == 16'd4);
                if (len16 >= 16'(HDR_BYTES)) begin
                  n_res = NR_W'(HDR_BYTES);
                end else begin
                  n_res = len16[NR_W-1:0];
                end
                bytes_out_nxt = MAX_LEN_W'(n_res);
                phase_nxt     = (len16 <= 16'(HDR_BYTES)) ? PH_IDLE : PH_BODY;
              end
            end
          endcase
        end else begin
          // Packet body: pass the byte through, flag the last one.
          bytes_out_nxt     = bytes_inc;
          res[0].data_byte  = in_ch.rx_byte;
          n_res             = NR_W'(1);
          if (bytes_inc == pkt_len_r) begin
            res[0].packet_end = 1'b1;
            phase_nxt         = PH_IDLE;
          end
        end
      end
    end
  end

  // Result queue: shift out on drain, append new results behind the rest.
  always_comb begin
    base = cnt_r - CNT_W'(drain);
    for (int i = 0; i < QD; i++) begin
      if (drain && (i < QD - 1)) begin
        queue_nxt[i] = queue_r[i + 1];
      end else begin
        queue_nxt[i] = queue_r[i];
      end
      for (int k = 0; k < HDR_BYTES; k++) begin
        if ((NR_W'(k) < n_res) && (CNT_W'(i) == base + CNT_W'(k))) begin
          queue_nxt[i] = res[k];
        end
      end
    end
    cnt_nxt = base + CNT_W'(n_res);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      pos_r       <= '0;
      exp_seq_r   <= '0;
      len_hi_r    <= '0;
      pkt_len_r   <= '0;
      bytes_out_r <= '0;
      held_r      <= '0;
      cnt_r       <= '0;
      max_len_r   <= MAX_LEN_RESET;
    end else begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      exp_seq_r   <= exp_seq_nxt;
      len_hi_r    <= len_hi_nxt;
      pkt_len_r   <= pkt_len_nxt;
      bytes_out_r <= bytes_out_nxt;
      held_r      <= held_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
    end
  end

  // Queue payload needs no reset.
  always_ff @(posedge clk) begin
    queue_r <= queue_nxt;
  end

  // The queue never holds more than its depth.
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CNT_W'(QD))
    else $error("result queue overflow");

  // In a packet body the emitted count stays below the packet length.
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> (bytes_out_r < pkt_len_r))
    else $error("body byte count reached packet length");

  // A sequence byte yields at most one result, and that one is an abort.
  assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_ch.frag_start && (n_res != '0)) |->
      ((n_res == NR_W'(1)) && res[0].packet_abort))
    else $error("sequence byte produced a non-abort result");

endmodule
